// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file bbod_checker.sv.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bbod_pkg.sv =====
// ---------------------------------------------------------------------------
// bbod_pkg
// Types, constants and control structs of the bounding box outline drawer.
// ---------------------------------------------------------------------------
`default_nettype none

package bbod_pkg;

    localparam int FRAME_WIDTH  = 256;
    localparam int FRAME_HEIGHT = 256;
    localparam int STORE_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);

    localparam int CMD_W     = 2;
    localparam int ADDR_IN_W = 16;
    localparam int PIX_W     = 12;
    localparam int COORD_W   = 8;
    localparam int CLASS_W   = 8;
    localparam int PITCH_W   = 9;
    localparam int BASE_W    = COORD_W + PITCH_W;
    localparam int DRAW_AW   = (STORE_AW + 1 > BASE_W + 1) ? STORE_AW + 1 : BASE_W + 1;

    localparam logic [PITCH_W-1:0] PITCH_RESET  = 9'd256;
    localparam logic [PIX_W-1:0]   COLOUR_RED   = 12'h00f;
    localparam logic [PIX_W-1:0]   COLOUR_GREEN = 12'h0f0;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [ADDR_IN_W-1:0] pixel_address;
        logic [PIX_W-1:0]     pixel_value;
        logic [COORD_W-1:0]   left_col;
        logic [COORD_W-1:0]   top_row;
        logic [COORD_W-1:0]   right_col;
        logic [COORD_W-1:0]   bottom_row;
        logic [CLASS_W-1:0]   box_class;
        logic                 box_suppressed;
    } cmd_beat_t;

    typedef struct packed {
        logic [PIX_W-1:0] read_pixel;
        logic             out_of_range;
    } rsp_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL_TOP,
        ST_MUL_BOT,
        ST_INIT,
        ST_H_A,
        ST_H_B,
        ST_V_A,
        ST_V_B,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        WSEL_NONE,
        WSEL_PIX,
        WSEL_HA,
        WSEL_HB,
        WSEL_VA,
        WSEL_VB
    } wsel_t;

    typedef struct packed {
        logic  latch_in;
        logic  rd_en;
        wsel_t wsel;
        logic  mul_top;
        logic  mul_bot;
        logic  init_ptr;
        logic  step_h;
        logic  start_v;
        logic  step_v;
        logic  load_out;
    } dp_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             suppressed;
        logic             h_go;
        logic             v_go;
        logic             h_last;
        logic             v_last;
        logic             out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bounding_box_outline_drawer.sv =====
// ---------------------------------------------------------------------------
// bounding_box_outline_drawer
// Frame store with pixel write, pixel read and box outline draw commands.
// ---------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd_beat) takes one command per beat;
//   rsp channel (rsp_valid/rsp_ready/rsp_beat) returns exactly one beat per
//   command: read_pixel for a read (zero otherwise) and out_of_range when a
//   store address was dropped. pitch_we/pitch_wdata set the row pitch; write
//   it only while no command is in flight.
// Sequence:
//   write, read, unused code or suppressed box: DECODE, then DONE. draw:
//   DECODE, MUL_TOP, MUL_BOT, INIT, the horizontal and then the vertical
//   edge states where the box has them, then DONE. The single write port of
//   the frame store takes one outline pixel per cycle of the edge walk.
//   One command is in work at a time; the next is accepted the cycle after
//   its result enters the output register.
// Reset: rst_n clears control and sets the pitch to 256; store contents stay
//   undefined until written, and no clearing pass runs.
// Stall: a held result blocks only the finish of the following command.
// ---------------------------------------------------------------------------
`default_nettype none

module bounding_box_outline_drawer
    import bbod_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire cmd_beat_t          cmd_beat,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output rsp_beat_t               rsp_beat,
    input  wire logic               pitch_we,
    input  wire logic [PITCH_W-1:0] pitch_wdata
);

    dp_ctl_t ctl;
    dp_sts_t sts;

    bbod_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    bbod_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_beat    (cmd_beat),
        .pitch_we    (pitch_we),
        .pitch_wdata (pitch_wdata),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_beat    (rsp_beat),
        .ctl         (ctl),
        .sts         (sts)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bbod_ctrl.sv =====
// ---------------------------------------------------------------------------
// bbod_ctrl
// Sequencer: decodes a command and walks the outline edges two pixels per step.
// ---------------------------------------------------------------------------
`default_nettype none

module bbod_ctrl
    import bbod_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cmd_valid,
    output logic         cmd_ready,
    input  wire dp_sts_t sts,
    output dp_ctl_t      ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.command == CMD_DRAW && !sts.suppressed)
                begin
                    state_next = ST_MUL_TOP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL_TOP: state_next = ST_MUL_BOT;
            ST_MUL_BOT: state_next = ST_INIT;
            ST_INIT:
            begin
                if (sts.h_go)
                begin
                    state_next = ST_H_A;
                end
                else if (sts.v_go)
                begin
                    state_next = ST_V_A;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_H_A: state_next = ST_H_B;
            ST_H_B:
            begin
                if (!sts.h_last)
                begin
                    state_next = ST_H_A;
                end
                else if (sts.v_go)
                begin
                    state_next = ST_V_A;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_V_A: state_next = ST_V_B;
            ST_V_B:
            begin
                if (sts.v_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_V_A;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        ctl.wsel  = WSEL_NONE;
        cmd_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready    = 1'b1;
                ctl.latch_in = cmd_valid;
            end
            ST_DECODE:
            begin
                case (sts.command)
                    CMD_WRITE: ctl.wsel  = WSEL_PIX;
                    CMD_READ:  ctl.rd_en = 1'b1;
                    default:   ctl.wsel  = WSEL_NONE;
                endcase
            end
            ST_MUL_TOP: ctl.mul_top  = 1'b1;
            ST_MUL_BOT: ctl.mul_bot  = 1'b1;
            ST_INIT:    ctl.init_ptr = 1'b1;
            ST_H_A:     ctl.wsel     = WSEL_HA;
            ST_H_B:
            begin
                ctl.wsel = WSEL_HB;
                if (sts.h_last)
                begin
                    ctl.start_v = 1'b1;
                end
                else
                begin
                    ctl.step_h = 1'b1;
                end
            end
            ST_V_A:     ctl.wsel     = WSEL_VA;
            ST_V_B:
            begin
                ctl.wsel   = WSEL_VB;
                ctl.step_v = !sts.v_last;
            end
            ST_DONE:    ctl.load_out = sts.out_free;
            default:    ctl.wsel     = WSEL_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bbod_datapath.sv =====
// ---------------------------------------------------------------------------
// bbod_datapath
// Frame store, edge address generators, pitch register and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module bbod_datapath
    import bbod_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cmd_beat_t    cmd_beat,
    input  wire logic         pitch_we,
    input  wire logic [PITCH_W-1:0] pitch_wdata,
    output logic              rsp_valid,
    input  wire logic         rsp_ready,
    output rsp_beat_t         rsp_beat,
    input  wire dp_ctl_t      ctl,
    output dp_sts_t           sts
);

    cmd_beat_t          item_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic [BASE_W-1:0]  top_base_reg;
    logic [BASE_W-1:0]  bot_base_reg;
    logic [DRAW_AW-1:0] h_a_reg;
    logic [DRAW_AW-1:0] h_b_reg;
    logic [DRAW_AW-1:0] v_a_reg;
    logic [DRAW_AW-1:0] v_b_reg;
    logic [COORD_W-1:0] step_reg;
    logic               oor_reg;
    logic [PIX_W-1:0]   rd_data_reg;
    logic               rsp_valid_reg;
    rsp_beat_t          rsp_beat_reg;

    logic [PIX_W-1:0]   store_mem [STORE_DEPTH];

    logic [COORD_W-1:0] mul_operand;
    logic [BASE_W-1:0]  product;
    logic [COORD_W-1:0] h_len;
    logic [COORD_W-1:0] v_len;
    logic [DRAW_AW-1:0] waddr;
    logic [PIX_W-1:0]   wdata;
    logic [PIX_W-1:0]   colour;
    logic               wr_req;
    logic               wr_in_range;
    logic [DRAW_AW-1:0] rd_addr;
    logic               rd_in_range;

    assign mul_operand = ctl.mul_top ? item_reg.top_row : item_reg.bottom_row;
    assign product     = BASE_W'(mul_operand) * BASE_W'(pitch_reg);
    assign h_len       = item_reg.right_col - item_reg.left_col;
    assign v_len       = item_reg.bottom_row - item_reg.top_row;
    assign colour      = (item_reg.box_class == '0) ? COLOUR_RED : COLOUR_GREEN;

    always_comb
    begin
        waddr  = '0;
        wr_req = 1'b1;
        case (ctl.wsel)
            WSEL_PIX: waddr = DRAW_AW'(item_reg.pixel_address);
            WSEL_HA:  waddr = h_a_reg;
            WSEL_HB:  waddr = h_b_reg;
            WSEL_VA:  waddr = v_a_reg;
            WSEL_VB:  waddr = v_b_reg;
            default:  wr_req = 1'b0;
        endcase
    end

    assign wdata       = (ctl.wsel == WSEL_PIX) ? item_reg.pixel_value : colour;
    assign wr_in_range = waddr < DRAW_AW'(STORE_DEPTH);
    assign rd_addr     = DRAW_AW'(item_reg.pixel_address);
    assign rd_in_range = rd_addr < DRAW_AW'(STORE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (wr_req && wr_in_range)
        begin
            store_mem[waddr[STORE_AW-1:0]] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr[STORE_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= PITCH_RESET;
        end
        else if (pitch_we)
        begin
            pitch_reg <= pitch_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            item_reg <= cmd_beat;
        end
        if (ctl.mul_top)
        begin
            top_base_reg <= product;
        end
        if (ctl.mul_bot)
        begin
            bot_base_reg <= product;
        end
        if (ctl.init_ptr)
        begin
            h_a_reg  <= DRAW_AW'(top_base_reg) + DRAW_AW'(item_reg.left_col);
            h_b_reg  <= DRAW_AW'(bot_base_reg) + DRAW_AW'(item_reg.left_col);
            v_a_reg  <= DRAW_AW'(top_base_reg) + DRAW_AW'(item_reg.left_col);
            v_b_reg  <= DRAW_AW'(top_base_reg) + DRAW_AW'(item_reg.right_col);
            step_reg <= '0;
        end
        else if (ctl.step_h)
        begin
            h_a_reg  <= h_a_reg + DRAW_AW'(1);
            h_b_reg  <= h_b_reg + DRAW_AW'(1);
            step_reg <= step_reg + COORD_W'(1);
        end
        else if (ctl.start_v)
        begin
            step_reg <= '0;
        end
        else if (ctl.step_v)
        begin
            v_a_reg  <= v_a_reg + DRAW_AW'(pitch_reg);
            v_b_reg  <= v_b_reg + DRAW_AW'(pitch_reg);
            step_reg <= step_reg + COORD_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            oor_reg <= 1'b0;
        end
        else if ((wr_req && !wr_in_range) || (ctl.rd_en && !rd_in_range))
        begin
            oor_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctl.load_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            rsp_beat_reg.read_pixel   <= (item_reg.command == CMD_READ && !oor_reg)
                                         ? rd_data_reg : '0;
            rsp_beat_reg.out_of_range <= oor_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_beat_reg;

    assign sts.command    = item_reg.command;
    assign sts.suppressed = item_reg.box_suppressed;
    assign sts.h_go       = item_reg.right_col >= item_reg.left_col;
    assign sts.v_go       = item_reg.bottom_row >= item_reg.top_row;
    assign sts.h_last     = step_reg == h_len;
    assign sts.v_last     = step_reg == v_len;
    assign sts.out_free   = !rsp_valid_reg || rsp_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/bbod_checker.sv =====
// ---------------------------------------------------------------------------
// bbod_checker
// Port-level assertions for the bounding box outline drawer.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bbod_checker
    import bbod_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    input  wire logic      cmd_ready,
    input  wire logic      rsp_valid,
    input  wire logic      rsp_ready,
    input  wire rsp_beat_t rsp_beat
);

    `CHK_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "ready after accept")
    `CHK_NOW(a_ready_with_result, $rose(rsp_valid), cmd_ready, "result without return to idle")
    `CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_beat), "rsp beat lost")

endmodule

bind bounding_box_outline_drawer bbod_checker u_bbod_checker (.*);

`default_nettype wire

// ===== tb/sv/outline_drawer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// outline_drawer_checker
// Watches the command, response and pitch ports of the outline drawer, keeps
// its own copy of the frame store and row pitch, works out the response owed
// for every accepted command and compares each response beat field by field.
// ----------------------------------------------------------------------------
module outline_drawer_checker
    import bbod_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic               cmd_ready,
    input  cmd_beat_t          cmd_beat,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  rsp_beat_t          rsp_beat,
    input  logic               pitch_we,
    input  logic [PITCH_W-1:0] pitch_wdata,
    output int                 failures,
    output int                 owed
);

    logic [PIX_W-1:0]   frame_copy [STORE_DEPTH];
    logic [PITCH_W-1:0] row_pitch = PITCH_RESET;
    rsp_beat_t          owed_rsp [$];
    int                 fail_count = 0;
    int                 owed_count = 0;

    assign failures = fail_count;
    assign owed     = owed_count;

    function automatic bit place_pixel(input int addr, input logic [PIX_W-1:0] pix);
        if (addr < 0 || addr >= STORE_DEPTH)
        begin
            return 1'b0;
        end
        frame_copy[addr] = pix;
        return 1'b1;
    endfunction

    function automatic rsp_beat_t execute_command(input cmd_beat_t b);
        rsp_beat_t        r;
        logic [PIX_W-1:0] colour;
        int               l;
        int               t;
        int               rc;
        int               bm;
        int               p;
        int               top_base;
        int               bot_base;
        int               k;
        r        = '0;
        l        = int'(b.left_col);
        t        = int'(b.top_row);
        rc       = int'(b.right_col);
        bm       = int'(b.bottom_row);
        p        = int'(row_pitch);
        top_base = t * p;
        bot_base = bm * p;
        if (b.command == CMD_WRITE)
        begin
            if (!place_pixel(int'(b.pixel_address), b.pixel_value))
            begin
                r.out_of_range = 1'b1;
            end
        end
        else if (b.command == CMD_READ)
        begin
            if (int'(b.pixel_address) < STORE_DEPTH)
            begin
                r.read_pixel = frame_copy[b.pixel_address];
            end
            else
            begin
                r.out_of_range = 1'b1;
            end
        end
        else if (b.command == CMD_DRAW && !b.box_suppressed)
        begin
            colour = (b.box_class == '0) ? COLOUR_RED : COLOUR_GREEN;
            if (rc >= l)
            begin
                for (k = 0; k <= rc - l; k++)
                begin
                    if (!place_pixel(top_base + l + k, colour))
                    begin
                        r.out_of_range = 1'b1;
                    end
                    if (!place_pixel(bot_base + l + k, colour))
                    begin
                        r.out_of_range = 1'b1;
                    end
                end
            end
            if (bm >= t)
            begin
                for (k = 0; k <= bm - t; k++)
                begin
                    if (!place_pixel(top_base + l + k * p, colour))
                    begin
                        r.out_of_range = 1'b1;
                    end
                    if (!place_pixel(top_base + rc + k * p, colour))
                    begin
                        r.out_of_range = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_beat_t want;
        if (!rst_n)
        begin
            row_pitch = PITCH_RESET;
            owed_rsp.delete();
            owed_count = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (owed_rsp.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: response beat with none owed, expected none actual %h",
                             $time, rsp_beat);
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    if (rsp_beat.read_pixel !== want.read_pixel)
                    begin
                        fail_count++;
                        $display("%0t: read_pixel mismatch, expected %h actual %h",
                                 $time, want.read_pixel, rsp_beat.read_pixel);
                    end
                    if (rsp_beat.out_of_range !== want.out_of_range)
                    begin
                        fail_count++;
                        $display("%0t: out_of_range mismatch, expected %b actual %b",
                                 $time, want.out_of_range, rsp_beat.out_of_range);
                    end
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                owed_rsp.push_back(execute_command(cmd_beat));
            end
            if (pitch_we)
            begin
                row_pitch = pitch_wdata;
            end
            owed_count = owed_rsp.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the bounding box outline drawer: directed pixel writes, reads
// and box draws over the edge cases, then random command streams under
// several row pitch settings, with bursty command traffic and a stalling
// response side. The checker beside the block judges every response beat.
// ----------------------------------------------------------------------------
module tb;
    import bbod_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_ITEMS  = 650;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 4 * (RANDOM_ITEMS + 30) * 1200;
    localparam int ADDR_KEEP     = 4096;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    cmd_beat_t          cmd_beat = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_beat_t          rsp_beat;
    logic               pitch_we = 1'b0;
    logic [PITCH_W-1:0] pitch_wdata = '0;

    int mismatches;
    int owed_results;
    int cycle_count = 0;
    int burst_left = 0;
    int ready_mode = 0;
    int ready_left = 0;
    int cur_pitch = int'(PITCH_RESET);
    int written_addr [$];
    int n_write = 0;
    int n_read = 0;
    int n_draw = 0;
    int n_suppressed = 0;
    int n_spare = 0;
    int n_pitch = 0;

    always #5 clk = ~clk;

    bounding_box_outline_drawer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_beat    (cmd_beat),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_beat    (rsp_beat),
        .pitch_we    (pitch_we),
        .pitch_wdata (pitch_wdata)
    );

    outline_drawer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_beat    (cmd_beat),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_beat    (rsp_beat),
        .pitch_we    (pitch_we),
        .pitch_wdata (pitch_wdata),
        .failures    (mismatches),
        .owed        (owed_results)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // response side: switch between free flow, coin flips and heavy stalls
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode <= $urandom_range(0, 2);
            ready_left <= $urandom_range(32, 256);
        end
        else
        begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic void remember(input int addr);
        if (addr >= 0 && addr < STORE_DEPTH)
        begin
            written_addr.push_back(addr);
        end
        while (written_addr.size() > ADDR_KEEP)
        begin
            void'(written_addr.pop_front());
        end
    endfunction

    function automatic int pick_written();
        int lo;
        lo = 0;
        if (written_addr.size() > 64 && $urandom_range(0, 1) == 1)
        begin
            lo = written_addr.size() - 64;
        end
        return written_addr[$urandom_range(lo, written_addr.size() - 1)];
    endfunction

    function automatic cmd_beat_t noise_beat();
        cmd_beat_t b;
        b.command        = CMD_SPARE;
        b.pixel_address  = 16'($urandom);
        b.pixel_value    = 12'($urandom);
        b.left_col       = 8'($urandom);
        b.top_row        = 8'($urandom);
        b.right_col      = 8'($urandom);
        b.bottom_row     = 8'($urandom);
        b.box_class      = 8'($urandom);
        b.box_suppressed = 1'($urandom);
        return b;
    endfunction

    function automatic cmd_beat_t pixel_beat(input logic [CMD_W-1:0] code, input int addr,
                                             input int pix);
        cmd_beat_t b;
        b               = noise_beat();
        b.command       = code;
        b.pixel_address = 16'(addr);
        b.pixel_value   = 12'(pix);
        return b;
    endfunction

    function automatic cmd_beat_t outline_beat(input int l, input int t, input int r,
                                               input int bt, input int cls, input int supp);
        cmd_beat_t b;
        b                = noise_beat();
        b.command        = CMD_DRAW;
        b.left_col       = 8'(l);
        b.top_row        = 8'(t);
        b.right_col      = 8'(r);
        b.bottom_row     = 8'(bt);
        b.box_class      = 8'(cls);
        b.box_suppressed = 1'(supp);
        return b;
    endfunction

    function automatic cmd_beat_t box_beat(input cmd_beat_t b);
        int shape;
        int w;
        int h;
        b.command        = CMD_DRAW;
        b.box_suppressed = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 2) == 0)
        begin
            b.box_class = '0;
        end
        shape = $urandom_range(0, 99);
        // keep most boxes small; a few keep fully random corners
        if (shape >= 3)
        begin
            w = $urandom_range(0, 12);
            h = $urandom_range(0, 12);
            b.right_col  = (int'(b.left_col) + w > 255) ? 8'd255 : 8'(int'(b.left_col) + w);
            b.bottom_row = (int'(b.top_row) + h > 255) ? 8'd255 : 8'(int'(b.top_row) + h);
            if (shape < 10 && b.left_col != '0)
            begin
                b.right_col = 8'($urandom_range(0, int'(b.left_col) - 1));
            end
            if (shape >= 10 && shape < 17 && b.top_row != '0)
            begin
                b.bottom_row = 8'($urandom_range(0, int'(b.top_row) - 1));
            end
        end
        return b;
    endfunction

    function automatic void note_beat(input cmd_beat_t b);
        int l;
        int t;
        int r;
        int bt;
        l  = int'(b.left_col);
        t  = int'(b.top_row);
        r  = int'(b.right_col);
        bt = int'(b.bottom_row);
        case (b.command)
            CMD_WRITE:
            begin
                n_write++;
                remember(int'(b.pixel_address));
            end
            CMD_READ:
            begin
                n_read++;
            end
            CMD_DRAW:
            begin
                n_draw++;
                if (b.box_suppressed)
                begin
                    n_suppressed++;
                end
                else if (r >= l || bt >= t)
                begin
                    remember(l + t * cur_pitch);
                    remember(r + t * cur_pitch);
                    remember(l + bt * cur_pitch);
                    remember(r + bt * cur_pitch);
                end
            end
            default:
            begin
                n_spare++;
            end
        endcase
    endfunction

    task automatic issue(input cmd_beat_t b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        cmd_beat  <= b;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        note_beat(b);
    endtask

    task automatic settle();
        cmd_valid <= 1'b0;
        @(negedge clk);
        while (owed_results != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_pitch(input int value);
        settle();
        pitch_we    <= 1'b1;
        pitch_wdata <= PITCH_W'(value);
        @(negedge clk);
        pitch_we <= 1'b0;
        cur_pitch = value;
        n_pitch++;
    endtask

    task automatic random_item();
        cmd_beat_t b;
        int        pick;
        b    = noise_beat();
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            b.command = CMD_WRITE;
            if (written_addr.size() > 0 && $urandom_range(0, 1) == 1)
            begin
                b.pixel_address = 16'(pick_written());
            end
        end
        else if (pick < 60 && written_addr.size() > 0)
        begin
            b.command       = CMD_READ;
            b.pixel_address = 16'(pick_written());
        end
        else if (pick < 95)
        begin
            b = box_beat(b);
        end
        issue(b);
    endtask

    task automatic run_directed();
        cmd_beat_t spare;
        spare = '1;
        issue(pixel_beat(CMD_WRITE, 0, 12'hfff));
        issue(pixel_beat(CMD_WRITE, 16'hffff, 12'h000));
        issue(pixel_beat(CMD_WRITE, 16'h1234, 12'ha5a));
        issue(pixel_beat(CMD_READ, 0, 0));
        issue(pixel_beat(CMD_READ, 16'hffff, 0));
        issue(pixel_beat(CMD_READ, 16'h1234, 0));
        issue(spare);
        issue(outline_beat(2, 3, 6, 8, 0, 0));
        issue(pixel_beat(CMD_READ, 3 * 256 + 2, 0));
        issue(outline_beat(2, 3, 6, 8, 255, 1));
        issue(pixel_beat(CMD_READ, 8 * 256 + 6, 0));
        // vertical edges only, then horizontal edges only, then neither
        issue(outline_beat(10, 1, 5, 4, 1, 0));
        issue(pixel_beat(CMD_READ, 4 * 256 + 5, 0));
        issue(outline_beat(20, 9, 25, 6, 0, 0));
        issue(pixel_beat(CMD_READ, 9 * 256 + 25, 0));
        issue(outline_beat(30, 30, 29, 29, 127, 0));
        issue(outline_beat(40, 40, 40, 40, 2, 0));
        issue(pixel_beat(CMD_READ, 40 * 256 + 40, 0));
        issue(outline_beat(0, 0, 255, 255, 128, 0));
        issue(pixel_beat(CMD_READ, 16'hffff, 0));
        // rows past the end of the store
        set_pitch(511);
        issue(outline_beat(0, 200, 3, 201, 0, 0));
        // zero pitch folds every row onto row zero
        set_pitch(0);
        issue(outline_beat(5, 7, 9, 50, 0, 0));
        issue(pixel_beat(CMD_READ, 9, 0));
    endtask

    initial
    begin
        int pitch_plan [6];
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);
        run_directed();
        pitch_plan[0] = 1;
        pitch_plan[1] = 0;
        pitch_plan[2] = 511;
        pitch_plan[3] = $urandom_range(2, 255);
        pitch_plan[4] = $urandom_range(257, 510);
        pitch_plan[5] = 256;
        foreach (pitch_plan[i])
        begin
            set_pitch(pitch_plan[i]);
            repeat (RANDOM_ITEMS / 6) random_item();
        end
        settle();
        $display("Ran %0d pixel writes, %0d reads, %0d box draws (%0d suppressed), %0d spare codes",
                 n_write, n_read, n_draw, n_suppressed, n_spare);
        $display("over %0d row pitch settings, including 0, 1, 256 and 511", n_pitch + 1);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
